[rtl/tterm_pkg.sv]
// Shared constants and types for the text terminal cursor/scroll engine.
package tterm_pkg;

    // Screen geometry and field widths
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = 11;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int CHAR_W     = 8;
    localparam int CELL_W     = 16;

    // Character and attribute codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h07;

    // Request function codes
    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_FILL
    } state_t;

endpackage

[rtl/tterm_if.sv]
// Request and response channel interfaces of the text terminal engine.
interface tterm_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [tterm_pkg::CHAR_W-1:0]  char_code;
    logic [tterm_pkg::ADDR_W-1:0]  read_index;

    modport source (output valid, func, char_code, read_index, input ready);
    modport sink   (input valid, func, char_code, read_index, output ready);
endinterface

interface tterm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          wrote_cell;
    logic [tterm_pkg::ADDR_W-1:0]  cell_index;
    logic [tterm_pkg::CELL_W-1:0]  cell_entry;
    logic                          scrolled;
    logic [tterm_pkg::ROW_W-1:0]   cursor_row_out;
    logic [tterm_pkg::COL_W-1:0]   cursor_col_out;

    modport source (output valid, wrote_cell, cell_index, cell_entry, scrolled,
                    cursor_row_out, cursor_col_out, input ready);
    modport sink   (input valid, wrote_cell, cell_index, cell_entry, scrolled,
                    cursor_row_out, cursor_col_out, output ready);
endinterface

[rtl/text_terminal_cursor_scroll_core.sv]
// Text terminal engine: cursor, screen cell memory, scroll sequencer.
// Put without scroll: result registered in the cycle after the request. A read
// passes the memory read register, then the result register. A scroll runs one
// memory copy per cycle over all but the last row, then one fill write per cell
// of the bottom row. One request at a time; the next is taken once the result is
// taken or leaving. After rst_n the memory is swept to spaces in color 0x07, with
// requests held off; cursor and color register reset at once.
module text_terminal_cursor_scroll_core (
    input  logic                          clk,
    input  logic                          rst_n,
    tterm_req_if.sink                     req,
    tterm_rsp_if.source                   rsp,
    input  logic                          cfg_wr_en,
    input  logic [tterm_pkg::CHAR_W-1:0]  cfg_wr_data
);

    localparam int AW = tterm_pkg::ADDR_W;
    localparam logic [AW-1:0] COPY_END  = AW'(tterm_pkg::CELL_COUNT - tterm_pkg::COLUMNS);
    localparam logic [AW-1:0] LAST_CELL = AW'(tterm_pkg::CELL_COUNT - 1);
    localparam logic [AW-1:0] CELLS     = AW'(tterm_pkg::CELL_COUNT);
    localparam logic [AW-1:0] ROW_SPAN  = AW'(tterm_pkg::COLUMNS);
    localparam logic [tterm_pkg::COL_W-1:0] LAST_COL = tterm_pkg::COL_W'(tterm_pkg::COLUMNS - 1);
    localparam logic [tterm_pkg::ROW_W-1:0] LAST_ROW = tterm_pkg::ROW_W'(tterm_pkg::ROWS - 1);

    // Screen cell memory
    logic [tterm_pkg::CELL_W-1:0] mem [tterm_pkg::CELL_COUNT];
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [tterm_pkg::CELL_W-1:0] mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic [tterm_pkg::CELL_W-1:0] rd_data_reg;

    // Control and datapath registers
    tterm_pkg::state_t            state_reg, state_next;
    logic [AW-1:0]                cnt_reg, cnt_next;
    logic [tterm_pkg::ROW_W-1:0]  cursor_row_reg, cursor_row_next;
    logic [tterm_pkg::COL_W-1:0]  cursor_col_reg, cursor_col_next;
    logic [tterm_pkg::CHAR_W-1:0] color_reg;
    logic                         out_valid_reg, out_valid_next;
    logic                         wrote_reg, wrote_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic [tterm_pkg::CELL_W-1:0] entry_reg, entry_next;
    logic                         scrolled_reg, scrolled_next;

    // Helper terms for a put request
    logic                         accept;
    logic                         is_newline;
    logic                         wrap;
    logic                         row_last;
    logic [AW-1:0]                cursor_idx;
    logic [tterm_pkg::CELL_W-1:0] put_cell;
    logic [tterm_pkg::CELL_W-1:0] fill_cell;

    assign req.ready  = (state_reg == tterm_pkg::ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept     = req.valid && req.ready;
    assign is_newline = (req.char_code == tterm_pkg::NEWLINE_CODE);
    assign wrap       = is_newline || (cursor_col_reg == LAST_COL);
    assign row_last   = (cursor_row_reg == LAST_ROW);
    assign cursor_idx = AW'(cursor_row_reg) * ROW_SPAN + AW'(cursor_col_reg);
    assign put_cell   = {color_reg, req.char_code};
    assign fill_cell  = {color_reg, tterm_pkg::SPACE_CODE};

    // Response outputs
    assign rsp.valid          = out_valid_reg;
    assign rsp.wrote_cell     = wrote_reg;
    assign rsp.cell_index     = idx_reg;
    assign rsp.cell_entry     = entry_reg;
    assign rsp.scrolled       = scrolled_reg;
    assign rsp.cursor_row_out = cursor_row_reg;
    assign rsp.cursor_col_out = cursor_col_reg;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Color register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= tterm_pkg::RESET_COLOR;
        end
        else if (cfg_wr_en)
        begin
            color_reg <= cfg_wr_data;
        end
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tterm_pkg::ST_CLEAR;
            cnt_reg        <= '0;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        wrote_reg    <= wrote_next;
        idx_reg      <= idx_next;
        entry_reg    <= entry_next;
        scrolled_reg <= scrolled_next;
    end

    // Sequencer: next state, memory access, result
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        wrote_next      = wrote_reg;
        idx_next        = idx_reg;
        entry_next      = entry_reg;
        scrolled_next   = scrolled_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg;
        mem_wdata       = fill_cell;
        mem_re          = 1'b0;
        mem_raddr       = cnt_reg;

        unique case (state_reg)
            // reset sweep to blank cells
            tterm_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {tterm_pkg::RESET_COLOR, tterm_pkg::SPACE_CODE};
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = tterm_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            tterm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.func == tterm_pkg::FUNC_READ)
                    begin
                        // cell read: out-of-range index reads nothing
                        mem_re        = (req.read_index < CELLS);
                        mem_raddr     = req.read_index;
                        wrote_next    = 1'b0;
                        idx_next      = req.read_index;
                        scrolled_next = 1'b0;
                        state_next    = tterm_pkg::ST_READ;
                    end
                    else
                    begin
                        // put or newline; cursor advance and scroll decision
                        if (!is_newline)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cursor_idx;
                            mem_wdata = put_cell;
                        end
                        wrote_next      = !is_newline;
                        idx_next        = is_newline ? '0 : cursor_idx;
                        entry_next      = is_newline ? '0 : put_cell;
                        scrolled_next   = wrap && row_last;
                        cursor_col_next = wrap ? '0 : cursor_col_reg + 1'b1;
                        cursor_row_next = (wrap && !row_last) ? cursor_row_reg + 1'b1
                                                              : cursor_row_reg;
                        if (wrap && row_last)
                        begin
                            cnt_next   = '0;
                            state_next = tterm_pkg::ST_COPY;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                        end
                    end
                end
            end

            // read data arrives in the cycle after the address
            tterm_pkg::ST_READ:
            begin
                entry_next     = (idx_reg < CELLS) ? rd_data_reg : '0;
                out_valid_next = 1'b1;
                state_next     = tterm_pkg::ST_IDLE;
            end

            // move each cell up one row: read ahead, write back in the next cycle
            tterm_pkg::ST_COPY:
            begin
                if (cnt_reg != COPY_END)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_reg + ROW_SPAN;
                end
                if (cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg - 1'b1;
                    mem_wdata = rd_data_reg;
                end
                if (cnt_reg == COPY_END)
                begin
                    state_next = tterm_pkg::ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // blank the bottom row in the current color
            tterm_pkg::ST_FILL:
            begin
                mem_we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = tterm_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = tterm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
